FILE: design/round_robin_thread_scheduler_defines.svh
// assertion macros for the round robin thread scheduler
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rrts_pkg.sv
// shared types, codes and constants of the round robin thread scheduler
package rrts_pkg;

    localparam int MAX_THREADS_DEF  = 16;
    localparam int CONTEXT_BITS_DEF = 32;

    localparam int QUOTA_W   = 15;
    localparam int TICKS_W   = 16;
    localparam int CTX_FLD_W = 32;
    localparam int SLOT_FLD_W = 4;

    localparam logic [QUOTA_W-1:0] QUOTA_RESET = 15'd10;

    // command codes
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_CHECK  = 2'd1,
        CMD_SWITCH = 2'd2,
        CMD_CREATE = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NO_CHOICE = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_CHECK,
        S_WALK,
        S_SW_OUT,
        S_SW_IN,
        S_MOVE,
        S_CREATE,
        S_DONE
    } sched_state_t;

    // one command item
    typedef struct packed {
        logic [1:0]           command;
        logic [7:0]           tick_count;
        logic [CTX_FLD_W-1:0] saved_context;
        logic                 new_preemptible;
    } cmd_item_t;

    // one result item
    typedef struct packed {
        logic                  switch_needed;
        logic [CTX_FLD_W-1:0]  resume_context;
        logic [SLOT_FLD_W-1:0] current_thread;
        logic [SLOT_FLD_W-1:0] new_thread;
        logic [1:0]            status;
    } rsp_item_t;

    // per-thread table entry
    typedef struct packed {
        logic signed [TICKS_W-1:0] ticks;
        logic                      preempt;
        logic                      ready;
    } tt_entry_t;

    // slot zero after reset: full budget, preemptible, running
    localparam tt_entry_t TT_SLOT0_RESET = '{
        ticks:   $signed(TICKS_W'(QUOTA_RESET)),
        preempt: 1'b1,
        ready:   1'b0
    };

endpackage

FILE: design/rrts_thread_table.sv
// per-thread budget and flag memory with reset values held by valid bits
module rrts_thread_table
    import rrts_pkg::*;
#(
    parameter int DEPTH = MAX_THREADS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  tt_entry_t                wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output tt_entry_t                rdata
);

    tt_entry_t        mem [DEPTH];
    tt_entry_t        rd_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rd_vld_reg;
    logic             rd_zero_reg;

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // written marks, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_zero_reg <= 1'b1;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg  <= vld_reg[raddr];
            rd_zero_reg <= (raddr == '0);
        end
    end

    // unwritten entries read as their reset value
    always_comb
    begin
        if (rd_vld_reg)
        begin
            rdata = rd_reg;
        end
        else if (rd_zero_reg)
        begin
            rdata = TT_SLOT0_RESET;
        end
        else
        begin
            rdata = '0;
        end
    end

endmodule

FILE: design/rrts_run_list.sv
// ordered run list memory, entry zero reads as slot zero until written
module rrts_run_list
    import rrts_pkg::*;
#(
    parameter int DEPTH = MAX_THREADS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [$clog2(DEPTH)-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [$clog2(DEPTH)-1:0] rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rd_reg;
    logic          zero_wr_reg;
    logic          rd_blank_reg;

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // entry zero written mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_wr_reg  <= 1'b0;
            rd_blank_reg <= 1'b1;
        end
        else
        begin
            if (we && (waddr == '0))
            begin
                zero_wr_reg <= 1'b1;
            end
            rd_blank_reg <= (raddr == '0) && !zero_wr_reg;
        end
    end

    assign rdata = rd_blank_reg ? '0 : rd_reg;

endmodule

FILE: design/rrts_ctx_ram.sv
// saved context word memory
module rrts_ctx_ram
    import rrts_pkg::*;
#(
    parameter int DEPTH = MAX_THREADS_DEF,
    parameter int WIDTH = CONTEXT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/round_robin_thread_scheduler.sv
// round robin time slice thread scheduler, top level
//
//  channel  signals                      dir   item
//  cmd      cmd_valid/cmd_stall          in    cmd_item_t command item
//  rsp      rsp_valid/rsp_stall          out   rsp_item_t result item
//  cfg      cfg_valid/cfg_ready          in    slice quota write
//
// the run list walk reads one entry per cycle through the single read port
// of the run list memory.
// reset: quota 10, one thread in slot 0 running with a full budget, no
// clearing pass. a result waits in the output register under rsp_stall and
// the next item is taken once the sequencer is back in idle.
`include "round_robin_thread_scheduler_defines.svh"

module round_robin_thread_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_THREADS  = MAX_THREADS_DEF,
    parameter int CONTEXT_BITS = CONTEXT_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cmd_item_t          cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_item_t          rsp_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [QUOTA_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(MAX_THREADS);
    localparam int CNT_W  = $clog2(MAX_THREADS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_THREADS);

    sched_state_t       state_reg, state_next;
    cmd_item_t          item_reg, item_next;
    logic [QUOTA_W-1:0] quota_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOT_W-1:0]  running_reg, running_next;
    logic [SLOT_W-1:0]  chosen_reg, chosen_next;
    logic               chosen_valid_reg, chosen_valid_next;
    tt_entry_t          cur_reg, cur_next;
    logic [SLOT_W-1:0]  move_slot_reg, move_slot_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               s1_v_reg, s1_v_next;
    logic [CNT_W-1:0]   s1_idx_reg, s1_idx_next;
    logic               s2_v_reg, s2_v_next;
    logic [SLOT_W-1:0]  s2_slot_reg, s2_slot_next;
    logic               found_reg, found_next;
    rsp_item_t          res_reg, res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_item_reg, rsp_item_next;

    // memory ports
    logic                    tt_we;
    logic [SLOT_W-1:0]       tt_waddr, tt_raddr;
    tt_entry_t               tt_wdata, tt_rdata;
    logic                    ord_we;
    logic [SLOT_W-1:0]       ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic                    ctx_we;
    logic [SLOT_W-1:0]       ctx_waddr, ctx_raddr;
    logic [CONTEXT_BITS-1:0] ctx_wdata, ctx_rdata;

    // helpers
    logic                    issue_v;
    logic                    hit;
    logic                    walk_empty;
    logic                    due;
    logic                    out_free;
    logic [TICKS_W:0]        tick_diff;
    logic [TICKS_W-1:0]      tick_val;
    logic signed [TICKS_W-1:0] quota_ticks;
    logic [CNT_W-1:0]        prev_idx;
    logic [CNT_W-1:0]        last_idx;

    rrts_thread_table #(.DEPTH(MAX_THREADS)) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tt_we),
        .waddr (tt_waddr),
        .wdata (tt_wdata),
        .raddr (tt_raddr),
        .rdata (tt_rdata)
    );

    rrts_run_list #(.DEPTH(MAX_THREADS)) u_list (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    rrts_ctx_ram #(.DEPTH(MAX_THREADS), .WIDTH(CONTEXT_BITS)) u_ctx (
        .clk   (clk),
        .we    (ctx_we),
        .waddr (ctx_waddr),
        .wdata (ctx_wdata),
        .raddr (ctx_raddr),
        .rdata (ctx_rdata)
    );

    // handshake
    assign cmd_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // walk pipeline status
    assign issue_v    = (idx_reg < count_reg);
    assign hit        = s2_v_reg && tt_rdata.ready;
    assign walk_empty = !issue_v && !s1_v_reg && !s2_v_reg;
    assign prev_idx   = s1_idx_reg - CNT_W'(1);
    assign last_idx   = count_reg - CNT_W'(1);

    // budget arithmetic, saturating at the most negative value
    assign due         = (tt_rdata.ticks[TICKS_W-1] || (tt_rdata.ticks == '0))
                         && tt_rdata.preempt;
    assign tick_diff   = {tt_rdata.ticks[TICKS_W-1], tt_rdata.ticks}
                         - {{(TICKS_W-7){1'b0}}, item_reg.tick_count};
    assign tick_val    = (tick_diff[TICKS_W] != tick_diff[TICKS_W-1])
                         ? {1'b1, {(TICKS_W-1){1'b0}}} : tick_diff[TICKS_W-1:0];
    assign quota_ticks = $signed({1'b0, quota_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_item.command)
                        CMD_TICK:   state_next = S_TICK;
                        CMD_CHECK:  state_next = S_CHECK;
                        CMD_SWITCH: state_next = S_SW_OUT;
                        CMD_CREATE: state_next = S_CREATE;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_TICK:   state_next = S_DONE;
            S_CHECK:  state_next = due ? S_WALK : S_DONE;
            S_WALK:
            begin
                if (hit || walk_empty)
                begin
                    state_next = S_DONE;
                end
            end
            S_SW_OUT: state_next = chosen_valid_reg ? S_SW_IN : S_DONE;
            S_SW_IN:  state_next = S_MOVE;
            S_MOVE:
            begin
                if (!issue_v && !s1_v_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_CREATE: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        item_next         = item_reg;
        count_next        = count_reg;
        running_next      = running_reg;
        chosen_next       = chosen_reg;
        chosen_valid_next = chosen_valid_reg;
        cur_next          = cur_reg;
        move_slot_next    = move_slot_reg;
        idx_next          = idx_reg;
        s1_v_next         = s1_v_reg;
        s1_idx_next       = s1_idx_reg;
        s2_v_next         = s2_v_reg;
        s2_slot_next      = s2_slot_reg;
        found_next        = found_reg;
        res_next          = res_reg;
        rsp_item_next     = rsp_item_reg;
        rsp_valid_next    = rsp_valid_reg && rsp_stall;

        tt_we     = 1'b0;
        tt_waddr  = running_reg;
        tt_wdata  = tt_rdata;
        tt_raddr  = running_reg;
        ord_we    = 1'b0;
        ord_waddr = prev_idx[SLOT_W-1:0];
        ord_wdata = ord_rdata;
        ord_raddr = idx_reg[SLOT_W-1:0];
        ctx_we    = 1'b0;
        ctx_waddr = running_reg;
        ctx_wdata = CONTEXT_BITS'(item_reg.saved_context);
        ctx_raddr = chosen_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next       = cmd_item;
                    res_next        = '0;
                    res_next.status = STATUS_OK;
                end
            end
            // charge elapsed ticks to the running thread
            S_TICK:
            begin
                tt_we    = 1'b1;
                tt_wdata = '{ticks: $signed(tick_val), preempt: tt_rdata.preempt,
                             ready: tt_rdata.ready};
            end
            // decide whether a switch is due
            S_CHECK:
            begin
                chosen_valid_next = 1'b0;
                cur_next          = tt_rdata;
                idx_next          = '0;
                s1_v_next         = 1'b0;
                s2_v_next         = 1'b0;
            end
            // find the first ready thread in list order
            S_WALK:
            begin
                s1_v_next    = issue_v;
                s2_v_next    = s1_v_reg;
                s2_slot_next = ord_rdata;
                tt_raddr     = ord_rdata;
                if (issue_v)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    chosen_next            = s2_slot_reg;
                    chosen_valid_next      = 1'b1;
                    res_next.switch_needed = 1'b1;
                end
                else if (walk_empty)
                begin
                    // nobody ready: reload the running thread's budget
                    tt_we    = 1'b1;
                    tt_wdata = '{ticks: quota_ticks, preempt: cur_reg.preempt,
                                 ready: cur_reg.ready};
                end
            end
            // save outgoing context and mark it ready, or report that no successor was chosen
            S_SW_OUT:
            begin
                if (!chosen_valid_reg)
                begin
                    res_next.status = STATUS_NO_CHOICE;
                end
                else
                begin
                    ctx_we         = 1'b1;
                    tt_we          = 1'b1;
                    tt_wdata       = '{ticks: tt_rdata.ticks, preempt: tt_rdata.preempt,
                                       ready: 1'b1};
                    tt_raddr       = chosen_reg;
                    move_slot_next = running_reg;
                end
            end
            // start the incoming thread
            S_SW_IN:
            begin
                tt_we                   = 1'b1;
                tt_waddr                = chosen_reg;
                tt_wdata                = '{ticks: quota_ticks, preempt: tt_rdata.preempt,
                                            ready: 1'b0};
                res_next.resume_context = CTX_FLD_W'(ctx_rdata);
                running_next            = chosen_reg;
                chosen_valid_next       = 1'b0;
                idx_next                = '0;
                s1_v_next               = 1'b0;
                found_next              = 1'b0;
            end
            // move the outgoing thread to the list tail, one entry per cycle
            S_MOVE:
            begin
                s1_v_next   = issue_v;
                s1_idx_next = idx_reg;
                if (issue_v)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (s1_v_reg)
                begin
                    if (found_reg)
                    begin
                        ord_we = 1'b1;
                    end
                    else if (ord_rdata == move_slot_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                else if (!issue_v && found_reg)
                begin
                    ord_we    = 1'b1;
                    ord_waddr = last_idx[SLOT_W-1:0];
                    ord_wdata = move_slot_reg;
                end
            end
            // append a new ready thread, or report a full table
            S_CREATE:
            begin
                if (count_reg >= CNT_MAX)
                begin
                    res_next.status = STATUS_FULL;
                end
                else
                begin
                    ord_we              = 1'b1;
                    ord_waddr           = count_reg[SLOT_W-1:0];
                    ord_wdata           = count_reg[SLOT_W-1:0];
                    tt_we               = 1'b1;
                    tt_waddr            = count_reg[SLOT_W-1:0];
                    tt_wdata            = '{ticks: quota_ticks,
                                            preempt: item_reg.new_preemptible,
                                            ready: 1'b1};
                    ctx_we              = 1'b1;
                    ctx_waddr           = count_reg[SLOT_W-1:0];
                    count_next          = count_reg + CNT_W'(1);
                    res_next.new_thread = SLOT_FLD_W'(count_reg);
                end
            end
            // hand the result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_item_next                = res_reg;
                    rsp_item_next.current_thread = SLOT_FLD_W'(running_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            quota_reg        <= QUOTA_RESET;
            count_reg        <= CNT_W'(1);
            running_reg      <= '0;
            chosen_reg       <= '0;
            chosen_valid_reg <= 1'b0;
            idx_reg          <= '0;
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            found_reg        <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            running_reg      <= running_next;
            chosen_reg       <= chosen_next;
            chosen_valid_reg <= chosen_valid_next;
            idx_reg          <= idx_next;
            s1_v_reg         <= s1_v_next;
            s2_v_reg         <= s2_v_next;
            found_reg        <= found_next;
            rsp_valid_reg    <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                quota_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        cur_reg       <= cur_next;
        move_slot_reg <= move_slot_next;
        s1_idx_reg    <= s1_idx_next;
        s2_slot_reg   <= s2_slot_next;
        res_reg       <= res_next;
        rsp_item_reg  <= rsp_item_next;
    end

    // checks
    `RRTS_ASSERT_IMP(a_count_range, 1'b1, (count_reg != '0) && (count_reg <= CNT_MAX), "thread count out of range")
    `RRTS_ASSERT_IMP(a_choice_not_running, chosen_valid_reg, chosen_reg != running_reg, "chosen successor is the running thread")
    `RRTS_ASSERT_NXT(a_done_delivers, (state_reg == S_DONE) && out_free, rsp_valid_reg && (state_reg == S_IDLE), "finished item not delivered")
    `RRTS_ASSERT_NXT(a_count_grows, 1'b1, count_reg >= $past(count_reg), "thread count decreased")

endmodule

FILE: tb/round_robin_thread_scheduler_tb.sv
// self-checking testbench for the round robin thread scheduler
module round_robin_thread_scheduler_tb;
    import rrts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS       = MAX_THREADS_DEF;
    localparam int BUDGET_FLOOR = -32768;
    localparam int QUOTA_MAX    = 32767;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT        = 1000000;

    // shadow scheduler: thread table, run list and the results it predicts
    class sched_scoreboard;
        logic [3:0]  run_list[NSLOTS];
        int          n_threads;
        int          budget[NSLOTS];
        bit          is_ready[NSLOTS];
        bit          can_preempt[NSLOTS];
        logic [31:0] saved_ctx[NSLOTS];
        logic [3:0]  running;
        logic [3:0]  picked;
        bit          pick_valid;
        logic [14:0] quota;
        rsp_item_t   predicted_results[$];
        int          mismatches;

        function new();
            foreach (run_list[i])
            begin
                run_list[i]    = '0;
                budget[i]      = 0;
                is_ready[i]    = 1'b0;
                can_preempt[i] = 1'b0;
                saved_ctx[i]   = '0;
            end
            n_threads      = 1;
            quota          = QUOTA_RESET;
            budget[0]      = int'(quota);
            can_preempt[0] = 1'b1;
            running        = '0;
            picked         = '0;
            pick_valid     = 1'b0;
            mismatches     = 0;
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction

        // advance the shadow state by one accepted command item
        function void note_command(cmd_item_t it);
            rsp_item_t exp;
            int        left;
            int        pos;
            int        i;
            int        s;
            exp = '0;
            case (cmd_t'(it.command))
                CMD_TICK:
                begin
                    // charge ticks, saturating at the budget floor
                    left = budget[running] - int'(it.tick_count);
                    budget[running] = (left < BUDGET_FLOOR) ? BUDGET_FLOOR : left;
                end
                CMD_CHECK:
                begin
                    pick_valid = 1'b0;
                    if (budget[running] <= 0 && can_preempt[running])
                    begin
                        // first ready thread in run order
                        for (i = 0; i < n_threads; i++)
                        begin
                            if (!pick_valid && is_ready[run_list[i]])
                            begin
                                picked     = run_list[i];
                                pick_valid = 1'b1;
                            end
                        end
                        if (pick_valid)
                            exp.switch_needed = 1'b1;
                        else
                            budget[running] = int'(quota);
                    end
                end
                CMD_SWITCH:
                begin
                    if (!pick_valid)
                    begin
                        exp.status = STATUS_NO_CHOICE;
                    end
                    else
                    begin
                        saved_ctx[running] = it.saved_context;
                        is_ready[running]  = 1'b1;
                        // outgoing thread moves to the tail of the run list
                        pos = -1;
                        for (i = 0; i < n_threads; i++)
                        begin
                            if (pos < 0 && run_list[i] == running)
                                pos = i;
                        end
                        if (pos >= 0)
                        begin
                            for (i = pos; i + 1 < n_threads; i++)
                                run_list[i] = run_list[i + 1];
                            run_list[n_threads - 1] = running;
                        end
                        running            = picked;
                        budget[running]    = int'(quota);
                        is_ready[running]  = 1'b0;
                        exp.resume_context = saved_ctx[running];
                        pick_valid         = 1'b0;
                    end
                end
                default:
                begin
                    if (n_threads >= NSLOTS)
                    begin
                        exp.status = STATUS_FULL;
                    end
                    else
                    begin
                        s              = n_threads;
                        run_list[s]    = 4'(s);
                        budget[s]      = int'(quota);
                        is_ready[s]    = 1'b1;
                        can_preempt[s] = it.new_preemptible;
                        saved_ctx[s]   = it.saved_context;
                        n_threads      = s + 1;
                        exp.new_thread = 4'(s);
                    end
                end
            endcase
            exp.current_thread = running;
            predicted_results.push_back(exp);
        endfunction

        // compare one result item with the oldest prediction
        function void check_result(rsp_item_t got);
            rsp_item_t exp;
            if (predicted_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing pending: sw=%0b ctx=%h cur=%0d new=%0d st=%0d",
                             got.switch_needed, got.resume_context, got.current_thread,
                             got.new_thread, got.status);
            end
            else
            begin
                exp = predicted_results.pop_front();
                if (got.switch_needed !== exp.switch_needed ||
                    got.resume_context !== exp.resume_context ||
                    got.current_thread !== exp.current_thread ||
                    got.new_thread !== exp.new_thread ||
                    got.status !== exp.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp sw=%0b ctx=%h cur=%0d new=%0d st=%0d | got sw=%0b ctx=%h cur=%0d new=%0d st=%0d",
                                 exp.switch_needed, exp.resume_context, exp.current_thread,
                                 exp.new_thread, exp.status,
                                 got.switch_needed, got.resume_context, got.current_thread,
                                 got.new_thread, got.status);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               cmd_valid   = 1'b0;
    logic               cmd_stall;
    cmd_item_t          cmd_item    = '0;
    logic               rsp_valid;
    logic               rsp_stall   = 1'b0;
    rsp_item_t          rsp_item;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [QUOTA_W-1:0] cfg_data    = '0;

    int              idle_pct    = 0;
    int              stall_pct   = 0;
    bit              hold_req    = 1'b0;
    bit              hold_active = 1'b0;
    int              items_sent  = 0;
    int unsigned     cycles      = 0;
    sched_scoreboard sb          = new();

    round_robin_thread_scheduler uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        wait (hold_req);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    // receiver stall
    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp_stall <= hold_active || ($urandom_range(99) < stall_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp_item);
    end

    // offer one command item and hold it until taken
    task automatic send_cmd(cmd_t op, logic [7:0] ticks, logic [31:0] ctx, logic pre);
        cmd_item_t it;
        it.command         = op;
        it.tick_count      = ticks;
        it.saved_context   = ctx;
        it.new_preemptible = pre;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        do @(posedge clk); while (cmd_stall);
        sb.note_command(it);
        items_sent++;
    endtask

    // quota write once all results are in
    task automatic write_quota(logic [14:0] q);
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= q;
        do @(posedge clk); while (!cfg_ready);
        sb.quota = q;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // burn the running slice far past zero, then check and switch
    task automatic expire_slice(int n);
        repeat (n) send_cmd(CMD_TICK, 8'hFF, $urandom, 1'($urandom));
        send_cmd(CMD_CHECK, 8'($urandom), $urandom, 1'($urandom));
        send_cmd(CMD_SWITCH, 8'($urandom), $urandom, 1'($urandom));
    endtask

    // mostly tick/check/switch rounds with random content, some noise
    task automatic run_mix(int n);
        int   stop;
        cmd_t op;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            if ($urandom_range(99) < 75)
            begin
                if (sb.n_threads < NSLOTS - 1 && $urandom_range(7) == 0)
                    send_cmd(CMD_CREATE, 8'($urandom), $urandom, 1'b1);
                repeat ($urandom_range(1, 3))
                    send_cmd(CMD_TICK, ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                       : 8'($urandom_range(128, 255)),
                             $urandom, 1'($urandom));
                send_cmd(CMD_CHECK, 8'($urandom), $urandom, 1'($urandom));
                send_cmd(CMD_SWITCH, 8'($urandom), $urandom, 1'($urandom));
            end
            else
            begin
                // noise; creates stay preemptible so the rotation keeps going
                op = cmd_t'($urandom_range(3));
                if (op == CMD_CREATE && sb.n_threads >= NSLOTS - 1)
                    op = CMD_TICK;
                send_cmd(op, 8'($urandom), $urandom,
                         (op == CMD_CREATE) ? 1'b1 : 1'($urandom));
            end
        end
    endtask

    // main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset quota, no idling
        send_cmd(CMD_CHECK,  8'h00, 32'h0000_0000, 1'b0);
        send_cmd(CMD_SWITCH, 8'h00, 32'h0000_0000, 1'b0);
        send_cmd(CMD_TICK,   8'h00, 32'h0000_0000, 1'b0);
        send_cmd(CMD_TICK,   8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(CMD_CHECK,  8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(CMD_CREATE, 8'h00, 32'h0000_0000, 1'b1);
        send_cmd(CMD_CREATE, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(CMD_CHECK,  8'h00, 32'h0000_0000, 1'b0);
        send_cmd(CMD_TICK,   8'd10, 32'h0000_0000, 1'b0);
        send_cmd(CMD_CHECK,  8'h00, 32'h0000_0000, 1'b0);
        send_cmd(CMD_SWITCH, 8'h00, 32'hFFFF_FFFF, 1'b0);
        send_cmd(CMD_SWITCH, 8'h00, 32'h1234_5678, 1'b0);
        send_cmd(CMD_TICK,   8'hFF, 32'h0000_0000, 1'b0);
        send_cmd(CMD_CHECK,  8'h00, 32'h0000_0000, 1'b0);
        send_cmd(CMD_SWITCH, 8'h00, 32'h0000_0000, 1'b0);
        send_cmd(CMD_TICK,   8'd200, 32'h0000_0000, 1'b0);
        send_cmd(CMD_CHECK,  8'h00, 32'h0000_0000, 1'b0);
        send_cmd(CMD_SWITCH, 8'h00, 32'h5A5A_A5A5, 1'b0);

        // smallest quota, no idling, long receiver hold-off, budget underflow
        write_quota(15'd1);
        hold_req = 1'b1;
        expire_slice(130);
        run_mix(120);

        // largest quota, sender mostly idle
        write_quota(15'(QUOTA_MAX));
        idle_pct = 86;
        expire_slice(140);
        run_mix(90);

        // receiver mostly stalling
        write_quota(15'($urandom_range(2, 600)));
        idle_pct  = 0;
        stall_pct = 86;
        run_mix(110);

        // light idling on both sides
        write_quota(15'($urandom_range(2, 300)));
        idle_pct  = 12;
        stall_pct = 12;
        run_mix(110);

        // non-preemptible thread, full table, then rotate until it runs
        send_cmd(CMD_CREATE, 8'h00, $urandom, 1'b0);
        send_cmd(CMD_CREATE, 8'h00, $urandom, 1'b1);
        repeat (24)
        begin
            send_cmd(CMD_TICK, 8'hFF, $urandom, 1'($urandom));
            send_cmd(CMD_TICK, 8'hFF, $urandom, 1'($urandom));
            send_cmd(CMD_CHECK, 8'($urandom), $urandom, 1'($urandom));
            send_cmd(CMD_SWITCH, 8'($urandom), $urandom, 1'($urandom));
        end

        // drain
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
